// ===== hw/rtl/zlw_pkg.sv =====
// ----------------------------------------------------------------------------
// zlw_pkg
// Constants, types and the natural-log table for the zenith log weight block.
// ----------------------------------------------------------------------------
package zlw_pkg;

   // log table geometry
   localparam int LOG_TABLE_BITS = 8;
   localparam int TBL_SIZE       = (1 << LOG_TABLE_BITS) + 1;
   localparam int FRAC_BITS      = 15 - LOG_TABLE_BITS;

   // fixed-point constants
   localparam logic [23:0] LN2_Q24 = 24'd11629080;
   localparam int DVD_BITS = 41;   // exp_numerator * 2^16 + c
   localparam int DVS_BITS = 17;   // 2 * c

   // register indexes
   localparam logic [2:0] REG_LOG_AMPLITUDE = 3'd0;
   localparam logic [2:0] REG_POWER_TERM    = 3'd1;
   localparam logic [2:0] REG_EXP_NUMERATOR = 3'd2;
   localparam logic [2:0] REG_LOG_FLOOR     = 3'd3;
   localparam logic [2:0] REG_MIN_COSINE    = 3'd4;

   // reset values
   localparam logic [25:0] RST_LOG_AMPLITUDE = 26'h3F0CBFC;   // -996356
   localparam logic [23:0] RST_POWER_TERM    = 24'd109918;
   localparam logic [23:0] RST_EXP_NUMERATOR = 24'd51013;
   localparam logic [25:0] RST_LOG_FLOOR     = 26'h3380000;   // -13107200
   localparam logic [15:0] RST_MIN_COSINE    = 16'd145;

   typedef logic [24:0] rom_type [0:TBL_SIZE-1];

   // unsigned long division by shift and subtract, used while building the table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln(1 + k/N) in Q24 as 2*atanh(k/(2N+k)), series in Q31
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] pw;
      logic [63:0] sum;
      n = 64'd1 << LOG_TABLE_BITS;
      for (int k = 0; k < TBL_SIZE; k++) begin
         d   = 2 * n + 64'(k);
         z   = udiv64(64'(k) << 31, d);
         z2  = (z * z) >> 31;
         pw  = z;
         sum = 64'd0;
         for (int j = 0; j < 64; j++) begin
            if (pw != 64'd0) begin
               sum = sum + udiv64(pw, 64'(2 * j + 1));
               pw  = (pw * z2) >> 31;
            end
         end
         rom[k] = 25'((2 * sum + 64'd64) >> 7);
      end
      return rom;
   endfunction

   localparam rom_type LN_ROM = build_rom();

endpackage

// ===== hw/rtl/zenith_log_weight.sv =====
// ----------------------------------------------------------------------------
// zenith_log_weight
// Log prior weight log_amplitude + power*ln(c) - exp_numerator/c over the
// cosine of the zenith angle, saturated to Q9.16 and clamped to the floor.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------
//  request   req_cos_zenith                          start, busy (never high)
//  response  rsp_log_weight, rsp_at_floor            rsp_valid, one cycle
//  config    csr_index, csr_write_data               csr_write_enable
//
//  One item is taken every cycle. A result passes through the restoring
//  divider, which yields one quotient bit per pipeline stage, and then the
//  output register. The ln and power path runs beside the divider and waits
//  in a delay line. Synchronous reset clears the valid bits and loads the
//  register defaults. The receiver cannot stall.
//
module zenith_log_weight
   import zlw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [16:0] req_cos_zenith,
   output logic               rsp_valid,
   output logic signed [25:0] rsp_log_weight,
   output logic               rsp_at_floor,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [25:0]        csr_write_data
);

   localparam int NDIV = DVD_BITS;      // divider stages
   localparam int LN_STAGES = 4;        // ln / power path depth

   typedef struct packed {
      logic                  valid;
      logic                  gt;
      logic [DVS_BITS-1:0]   dvs;
      logic [DVD_BITS-1:0]   dvd;
      logic [DVS_BITS-1:0]   rem;
      logic [DVD_BITS-1:0]   quo;
   } div_stage_type;

   // configuration registers
   logic signed [25:0] log_amplitude_ff;
   logic [23:0]        power_term_ff;
   logic [23:0]        exp_numerator_ff;
   logic signed [25:0] log_floor_ff;
   logic [15:0]        min_cosine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_amplitude_ff <= RST_LOG_AMPLITUDE;
         power_term_ff    <= RST_POWER_TERM;
         exp_numerator_ff <= RST_EXP_NUMERATOR;
         log_floor_ff     <= RST_LOG_FLOOR;
         min_cosine_ff    <= RST_MIN_COSINE;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LOG_AMPLITUDE: log_amplitude_ff <= csr_write_data;
            REG_POWER_TERM:    power_term_ff    <= csr_write_data[23:0];
            REG_EXP_NUMERATOR: exp_numerator_ff <= csr_write_data[23:0];
            REG_LOG_FLOOR:     log_floor_ff     <= csr_write_data;
            REG_MIN_COSINE:    min_cosine_ff    <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   div_stage_type div_ff [0:NDIV];
   div_stage_type div_in [0:NDIV];
   logic [15:0]   uc_ff;

   // input stage seeds the divider, then one quotient bit per stage
   always_comb begin
      logic [DVS_BITS:0] trial;
      div_in[0].valid = start;
      div_in[0].gt    = $signed({req_cos_zenith[16], req_cos_zenith})
                        > $signed({2'b00, min_cosine_ff});
      div_in[0].dvs   = {req_cos_zenith[15:0], 1'b0};
      div_in[0].dvd   = {1'b0, exp_numerator_ff, 16'd0}
                        + {25'd0, req_cos_zenith[15:0]};
      div_in[0].rem   = '0;
      div_in[0].quo   = '0;
      for (int k = 1; k <= NDIV; k++) begin
         trial = {div_ff[k-1].rem, div_ff[k-1].dvd[DVD_BITS-1]};
         div_in[k].valid = div_ff[k-1].valid;
         div_in[k].gt    = div_ff[k-1].gt;
         div_in[k].dvs   = div_ff[k-1].dvs;
         div_in[k].dvd   = {div_ff[k-1].dvd[DVD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff[k-1].dvs}) begin
            div_in[k].rem = DVS_BITS'(trial - {1'b0, div_ff[k-1].dvs});
            div_in[k].quo = {div_ff[k-1].quo[DVD_BITS-2:0], 1'b1};
         end else begin
            div_in[k].rem = trial[DVS_BITS-1:0];
            div_in[k].quo = {div_ff[k-1].quo[DVD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NDIV; k++) div_ff[k] <= '0;
      end else begin
         for (int k = 0; k <= NDIV; k++) div_ff[k] <= div_in[k];
      end
   end

   always_ff @(posedge clock) begin
      uc_ff <= req_cos_zenith[15:0];
   end

   // ln stage 1: normalize and read the table
   logic [3:0]           p_in;
   logic [15:0]          m_in;
   logic [3:0]           shift_ff;
   logic [24:0]          lo_ff;
   logic [24:0]          hi_ff;
   logic [FRAC_BITS-1:0] r_ff;
   logic [LOG_TABLE_BITS-1:0] idx_in;

   always_comb begin
      p_in = 4'd0;
      for (int b = 0; b < 16; b++) begin
         if (uc_ff[b]) p_in = 4'(b);
      end
      m_in   = uc_ff << (4'd15 - p_in);
      idx_in = m_in[14:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      shift_ff <= 4'd15 - p_in;
      lo_ff    <= LN_ROM[{1'b0, idx_in}];
      hi_ff    <= LN_ROM[{1'b0, idx_in} + (LOG_TABLE_BITS+1)'(1)];
      r_ff     <= m_in[FRAC_BITS-1:0];
   end

   // ln stage 2: interpolate and add the exponent
   logic [24+FRAC_BITS:0] slope_prod;
   logic signed [29:0]    ln_ff;

   assign slope_prod = (hi_ff - lo_ff) * r_ff;

   always_ff @(posedge clock) begin
      ln_ff <= $signed({5'd0, lo_ff})
               + $signed({5'd0, slope_prod[24+FRAC_BITS:FRAC_BITS]})
               - $signed({2'b00, 28'(shift_ff) * 28'(LN2_Q24)});
   end

   // ln stage 3: power times ln
   logic signed [54:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, power_term_ff}) * ln_ff;
   end

   // ln stage 4: round half up to Q16
   logic signed [54:0] prod_rnd;
   logic signed [30:0] pterm_ff [LN_STAGES:NDIV];

   assign prod_rnd = prod_ff + 55'sd8388608;

   always_ff @(posedge clock) begin
      pterm_ff[LN_STAGES] <= prod_rnd[54:24];
      for (int k = LN_STAGES + 1; k <= NDIV; k++) pterm_ff[k] <= pterm_ff[k-1];
   end

   // output stage: combine, saturate, clamp to floor
   logic signed [43:0] sum_in;
   logic signed [25:0] sat_in;
   logic signed [25:0] w_in;
   logic               rsp_valid_ff;
   logic signed [25:0] rsp_log_weight_ff;
   logic               rsp_at_floor_ff;

   always_comb begin
      sum_in = 44'(log_amplitude_ff) + 44'(pterm_ff[NDIV])
               - $signed({3'b000, div_ff[NDIV].quo});
      if (sum_in > 44'sd33554431)       sat_in = 26'sh1FFFFFF;
      else if (sum_in < -44'sd33554432) sat_in = 26'sh2000000;
      else                              sat_in = sum_in[25:0];
      if (!div_ff[NDIV].gt || sat_in < log_floor_ff) w_in = log_floor_ff;
      else                                           w_in = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_ff[NDIV].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_log_weight_ff <= w_in;
      rsp_at_floor_ff   <= (w_in == log_floor_ff);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_log_weight = rsp_log_weight_ff;
   assign rsp_at_floor   = rsp_at_floor_ff;

endmodule

// ===== sim/zenith_log_weight_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zenith_log_weight_tb
// Self-checking bench for the zenith log weight block. Cosine transfers are
// sent with random gaps under several register settings (reset defaults,
// extremes, floor-dominated and random). A behavioral model of the log
// table, power, divide and clamp predicts every result, and each result is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module zenith_log_weight_tb;
   import zlw_pkg::*;

   localparam int LATENCY = 50;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [16:0] req_cos_zenith;
   logic               rsp_valid;
   logic signed [25:0] rsp_log_weight;
   logic               rsp_at_floor;
   logic               csr_write_enable;
   logic [2:0]         csr_index;
   logic [25:0]        csr_write_data;

   typedef struct {
      logic signed [25:0] log_weight;
      logic               at_floor;
   } weight_type;

   weight_type  pending_weights[$];
   int          errors;
   bit          burst_mode;
   longint      ln_table [0:(1 << LOG_TABLE_BITS)];

   // register mirror
   logic signed [25:0] amp_q;
   logic [23:0]        power_q;
   logic [23:0]        expnum_q;
   logic signed [25:0] floor_q;
   logic [15:0]        mincos_q;

   zenith_log_weight dut (.*);

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ln(1 + k/N) in Q24 through the atanh series in Q31
   task automatic fill_ln_table();
      longint unsigned n, z, z2, pw, acc;
      n = longint'(1) << LOG_TABLE_BITS;
      for (int k = 0; k <= (1 << LOG_TABLE_BITS); k++) begin
         z   = (longint'(k) << 31) / (2 * n + k);
         z2  = (z * z) >> 31;
         pw  = z;
         acc = 0;
         for (int j = 0; j < 64 && pw != 0; j++) begin
            acc += pw / (2 * j + 1);
            pw = (pw * z2) >> 31;
         end
         ln_table[k] = longint'((2 * acc + 64) >> 7);
      end
   endtask

   // natural log of c/32768 in Q24, c >= 1
   function automatic longint ln_cos(longint unsigned c);
      int              p;
      longint unsigned f, idx, r;
      longint          lo, hi;
      p = 15;
      while (p > 0 && c[p] == 1'b0) p--;
      f   = ((c << (15 - p)) & 64'hFFFF) - 32768;
      idx = f >> FRAC_BITS;
      r   = f & ((64'd1 << FRAC_BITS) - 1);
      lo  = ln_table[idx];
      hi  = ln_table[idx + 1];
      return lo + longint'(($unsigned(hi - lo) * r) >> FRAC_BITS)
             - longint'(15 - p) * longint'(LN2_Q24);
   endfunction

   function automatic weight_type predict_weight(logic signed [16:0] cos_in);
      weight_type      res;
      longint          c, w, pterm, eterm;
      c = longint'(cos_in);
      w = longint'(floor_q);
      if (c > longint'(mincos_q)) begin
         pterm = (longint'(power_q) * ln_cos(c) + (longint'(1) << 23)) >>> 24;
         eterm = longint'((($unsigned(longint'(expnum_q)) << 16) + c) / (2 * c));
         w = longint'(amp_q) + pterm - eterm;
         if (w > 33554431) w = 33554431;
         if (w < -33554432) w = -33554432;
         if (w < longint'(floor_q)) w = longint'(floor_q);
      end
      res.log_weight = w[25:0];
      res.at_floor   = (w == longint'(floor_q));
      return res;
   endfunction

   // one cosine transfer; start stays high between back-to-back transfers
   task automatic send_cos(logic signed [16:0] cos_in);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cos_zenith <= cos_in;
      do @(posedge clock); while (busy);
      pending_weights.push_back(predict_weight(cos_in));
   endtask

   // stop sending and wait until every result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [25:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_LOG_AMPLITUDE: amp_q    = data;
         REG_POWER_TERM:    power_q  = data[23:0];
         REG_EXP_NUMERATOR: expnum_q = data[23:0];
         REG_LOG_FLOOR:     floor_q  = data;
         REG_MIN_COSINE:    mincos_q = data[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [25:0] amp, logic [23:0] pw, logic [23:0] en,
                            logic [25:0] fl, logic [15:0] mc);
      drain();
      write_reg(REG_LOG_AMPLITUDE, amp);
      write_reg(REG_POWER_TERM, 26'(pw));
      write_reg(REG_EXP_NUMERATOR, 26'(en));
      write_reg(REG_LOG_FLOOR, fl);
      write_reg(REG_MIN_COSINE, 26'(mc));
   endtask

   // mostly valid cosines above zero, with some over one and some negative
   function automatic logic signed [16:0] rand_cos();
      case ($urandom_range(0, 9))
         0:       return 17'($urandom);
         1:       return 17'($urandom_range(0, 400));
         2:       return 17'($urandom_range(32768, 65535));
         default: return 17'($urandom_range(1, 32768));
      endcase
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
         send_cos(rand_cos());
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_directed_edges();
      logic signed [16:0] pts [$];
      pts = '{-17'sd65536, -17'sd1, 17'sd0, 17'sd1, 17'sd144, 17'sd145, 17'sd146,
              17'sd200, 17'sd16384, 17'sd32767, 17'sd32768, 17'sd32769,
              17'sd49152, 17'sd65535};
      foreach (pts[i]) send_cos(pts[i]);
   endtask

   task automatic test_reset_defaults();
      test_directed_edges();
      send_random(250);
   endtask

   task automatic test_extreme_high();
      write_all(26'h1FFFFFF, 24'hFFFFFF, 24'hFFFFFF, 26'h2000000, 16'd0);
      test_directed_edges();
      send_random(150);
   endtask

   task automatic test_floor_wins();
      write_all(26'h2000000, 24'd0, 24'd0, 26'h1FFFFFF, 16'd32768);
      test_directed_edges();
      send_random(60);
      write_all(26'h2000000, 24'hFFFFFF, 24'd0, 26'h2000000, 16'hFFFF);
      test_directed_edges();
      send_random(40);
   endtask

   task automatic test_ignored_index();
      drain();
      write_reg(3'd5, 26'h3FFFFFF);
      write_reg(3'd7, 26'h0);
      test_directed_edges();
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 6; ph++) begin
         write_all(26'($urandom), 24'($urandom_range(0, 300000)),
                   24'($urandom_range(0, 400000)),
                   26'(-$urandom_range(0, 20000000)), 16'($urandom_range(0, 2000)));
         send_random(80);
         // results pending: pause until everything is back
         drain();
         send_random(20);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      weight_type exp_w;
      if (!reset && rsp_valid) begin
         if (pending_weights.size() == 0) begin
            $display("%0t: unexpected result log_weight=%0d at_floor=%0b",
                     $time, rsp_log_weight, rsp_at_floor);
            errors++;
         end else begin
            exp_w = pending_weights.pop_front();
            if (rsp_log_weight !== exp_w.log_weight) begin
               $display("%0t: log_weight expected %0d actual %0d",
                        $time, exp_w.log_weight, rsp_log_weight);
               errors++;
            end
            if (rsp_at_floor !== exp_w.at_floor) begin
               $display("%0t: at_floor expected %0b actual %0b",
                        $time, exp_w.at_floor, rsp_at_floor);
               errors++;
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      errors           = 0;
      burst_mode       = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_cos_zenith   = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      amp_q    = RST_LOG_AMPLITUDE;
      power_q  = RST_POWER_TERM;
      expnum_q = RST_EXP_NUMERATOR;
      floor_q  = RST_LOG_FLOOR;
      mincos_q = RST_MIN_COSINE;
      fill_ln_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extreme_high();
      test_floor_wins();
      test_ignored_index();
      test_random_settings();
      drain();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/zlw_pkg.sv
hw/rtl/zenith_log_weight.sv
sim/zenith_log_weight_tb.sv
